// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// When the antecedent holds, the consequent must hold in the cycle after.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lcsr_pkg.sv =====
package lcsr_pkg;

    // Serial frame shape.
    localparam int DATA_BITS         = 24;
    localparam int HALF_PERIOD_TICKS = 1;
    localparam int TICK_W            = 4;
    localparam int BIT_W             = $clog2(DATA_BITS + 1);

    // Field widths.
    localparam int CODE_W     = 24;
    localparam int OFFSET_W   = 25;
    localparam int SCALE_W    = 32;
    localparam int GAIN_W     = 2;
    localparam int WEIGHT_W   = 32;
    localparam int COUNT_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Scaling arithmetic: |code - offset| << 24, divided by the Q16.16 scale.
    localparam int DIFF_W     = OFFSET_W + 1;
    localparam int MAG_W      = OFFSET_W;
    localparam int FRAC_SHIFT = 24;
    localparam int DIVIDEND_W = MAG_W + FRAC_SHIFT;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

    localparam logic [CODE_W-1:0]   CODE_FLIP   = 24'h80_0000;
    localparam logic [SCALE_W-1:0]  SCALE_RESET = 32'h0001_0000;
    localparam logic [GAIN_W-1:0]   GAIN_RESET  = 2'd1;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX  = 32'h7FFF_FFFF;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MIN  = 32'h8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ZERO_OFFSET = 2'd0,
        CFG_SCALE       = 2'd1,
        CFG_GAIN        = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_BIT_HIGH,
        PH_BIT_LOW,
        PH_GAIN_HIGH,
        PH_GAIN_LOW
    } phase_t;

    typedef enum logic [1:0] {
        STEP_WAIT,
        STEP_DIV,
        STEP_EMIT
    } step_t;

    typedef struct packed {
        logic action;
        logic data_pin;
    } in_word_t;

    typedef struct packed {
        logic                       clock_pin;
        logic                       busy_res;
        logic                       ready_seen;
        logic                       new_data;
        logic [CODE_W-1:0]          raw_code;
        logic signed [WEIGHT_W-1:0] weight_q8;
        logic [COUNT_W-1:0]         update_total;
        logic [COUNT_W-1:0]         not_ready_total;
    } out_word_t;

    typedef struct packed {
        logic busy;
        logic tick_step;
        logic start_read;
        logic refuse;
        logic clock_low;
        logic shift_bit;
        logic gain_step;
        logic div_start;
        logic finish;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic half_done;
        logic last_bit;
        logic last_pulse;
        logic div_done;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== rtl/lcsr_in_if.sv =====
interface lcsr_in_if;
    import lcsr_pkg::*;

    logic     valid;
    logic     ready;
    in_word_t word;

    modport source (output valid, output word, input ready);
    modport sink (input valid, input word, output ready);
endinterface

// ===== rtl/lcsr_out_if.sv =====
interface lcsr_out_if;
    import lcsr_pkg::*;

    logic      valid;
    logic      ready;
    out_word_t word;

    modport source (output valid, output word, input ready);
    modport sink (input valid, input word, output ready);
endinterface

// ===== rtl/load_cell_serial_reader_core.sv =====
// Serial reader for a 24-bit bridge converter. Each input word is one
// microsecond tick carrying the converter's data line level and an action
// (plain tick or update request), and each tick returns exactly one output
// word with the serial clock level, the busy and ready flags, the last raw
// code and the last weight in signed Q24.8 grams. A plain tick moves the
// controller to its emit step, which loads the word into the output
// register. The next tick is taken no earlier than the edge at which that
// word is taken, so a new tick is never taken while the last word waits.
// The tick that ends a read also runs the weight division on a restoring
// divider that retires one quotient bit per cycle over a 49-bit dividend.
`include "assert_macros.svh"

module load_cell_serial_reader_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [lcsr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lcsr_pkg::CFG_DATA_W-1:0]  cfg_data,
    lcsr_in_if.sink                          in_ch,
    lcsr_out_if.source                       out_ch
);
    import lcsr_pkg::*;

    // The controller walks the serial frame (clock high, clock low, data
    // sample, then the gain pulses), advancing on accepted ticks, and sequences
    // the division and the loading of the output register.
    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     in_ready;

    lcsr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_word  (in_ch.word),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the configuration registers, the frame counters,
    // the shift register, the stored results and counters, the divider and
    // the output register that lets a finished word wait for the sink.
    lcsr_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .data_pin  (in_ch.word.data_pin),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_word  (out_ch.word)
    );

    assign in_ch.ready = in_ready;

    // Outside a read the serial clock is always left low.
    `ASSERT_ALWAYS(a_top_clock_idle_low, clk, rst_n, !out_ch.valid || out_ch.word.busy_res || !out_ch.word.clock_pin, "serial clock high while idle")

endmodule

// ===== rtl/lcsr_div.sv =====
`include "assert_macros.svh"

module lcsr_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [lcsr_pkg::DIVIDEND_W-1:0]  dividend,
    input  logic [lcsr_pkg::SCALE_W-1:0]     divisor,
    output logic                             done,
    output logic [lcsr_pkg::DIVIDEND_W-1:0]  quotient
);
    import lcsr_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [SCALE_W-1:0]    rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [SCALE_W-1:0]    div_reg, div_next;
    logic [SCALE_W:0]      shifted;
    logic [SCALE_W:0]      trial;
    logic                  ge;

    // One restoring step per cycle, quotient bits shift in as dividend bits shift out.
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DIVIDEND_W-1]};
        trial     = shifted - {1'b0, div_reg};
        ge        = !trial[SCALE_W];
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? trial[SCALE_W-1:0] : shifted[SCALE_W-1:0];
            quo_next = {quo_reg[DIVIDEND_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIVIDEND_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    `ASSERT_ALWAYS(a_div_no_restart, clk, rst_n, !(start && busy_reg), "divider restarted while busy")
    `ASSERT_NEXT(a_div_done_single, clk, rst_n, done_reg, !done_reg && !busy_reg, "divider done not a single pulse")

endmodule

// ===== rtl/lcsr_dp.sv =====
`include "assert_macros.svh"

module lcsr_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [lcsr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lcsr_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             data_pin,
    input  lcsr_pkg::dp_cmd_t                cmd,
    output lcsr_pkg::dp_stat_t               stat,
    output logic                             out_valid,
    input  logic                             out_ready,
    output lcsr_pkg::out_word_t              out_word
);
    import lcsr_pkg::*;

    logic [OFFSET_W-1:0]  offset_reg, offset_next;
    logic [SCALE_W-1:0]   scale_reg, scale_next;
    logic [GAIN_W-1:0]    gain_reg, gain_next;
    logic [TICK_W-1:0]    tick_reg, tick_next;
    logic [BIT_W-1:0]     bit_reg, bit_next;
    logic [DATA_BITS-1:0] shift_reg, shift_next;
    logic                 clock_reg, clock_next;
    logic                 ready_reg, ready_next;
    logic                 new_reg, new_next;
    logic [CODE_W-1:0]    raw_reg, raw_next;
    logic [WEIGHT_W-1:0]  weight_reg, weight_next;
    logic [COUNT_W-1:0]   upd_reg, upd_next;
    logic [COUNT_W-1:0]   nr_reg, nr_next;
    logic                 out_valid_reg, out_valid_next;
    out_word_t            out_word_reg, out_word_next;

    logic [GAIN_W-1:0]     pulses;
    logic [CODE_W-1:0]     raw_code;
    logic [DIFF_W-1:0]     diff;
    logic [DIFF_W-1:0]     diff_abs;
    logic                  neg;
    logic [DIVIDEND_W-1:0] dividend;
    logic                  div_done;
    logic [DIVIDEND_W-1:0] quotient;
    logic                  over;
    logic [WEIGHT_W-1:0]   weight;

    lcsr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (scale_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // Sign and magnitude of the offset-corrected code, and the saturated weight.
    always_comb
    begin
        raw_code = CODE_W'(shift_reg) ^ CODE_FLIP;
        diff     = {{(DIFF_W - CODE_W){1'b0}}, raw_code} - {offset_reg[OFFSET_W-1], offset_reg};
        neg      = diff[DIFF_W-1];
        diff_abs = neg ? (~diff + 1'b1) : diff;
        dividend = {diff_abs[MAG_W-1:0], {FRAC_SHIFT{1'b0}}};
        over     = |quotient[DIVIDEND_W-1:WEIGHT_W-1];
        if (neg)
            weight = over ? WEIGHT_MIN : (~quotient[WEIGHT_W-1:0] + 1'b1);
        else
            weight = over ? WEIGHT_MAX : quotient[WEIGHT_W-1:0];
    end

    always_comb
    begin
        pulses          = (gain_reg == '0) ? GAIN_W'(1) : gain_reg;
        stat.half_done  = ({1'b0, tick_reg} + 1'b1) >= (TICK_W + 1)'(HALF_PERIOD_TICKS);
        stat.last_bit   = ({1'b0, bit_reg} + 1'b1) >= (BIT_W + 1)'(DATA_BITS);
        stat.last_pulse = ({1'b0, bit_reg} + 1'b1) >= (BIT_W + 1)'(pulses);
        stat.div_done   = div_done;
        stat.out_free   = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        offset_next    = offset_reg;
        scale_next     = scale_reg;
        gain_next      = gain_reg;
        tick_next      = tick_reg;
        bit_next       = bit_reg;
        shift_next     = shift_reg;
        clock_next     = clock_reg;
        ready_next     = ready_reg;
        new_next       = new_reg;
        raw_next       = raw_reg;
        weight_next    = weight_reg;
        upd_next       = upd_reg;
        nr_next        = nr_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_word_next  = out_word_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_ZERO_OFFSET: offset_next = cfg_data[OFFSET_W-1:0];
                CFG_SCALE:
                begin
                    if (cfg_data[SCALE_W-1:0] != '0)
                        scale_next = cfg_data[SCALE_W-1:0];
                end
                CFG_GAIN:        gain_next = cfg_data[GAIN_W-1:0];
                default:         ;
            endcase
        end

        if (cmd.tick_step)
            tick_next = stat.half_done ? '0 : tick_reg + 1'b1;
        if (cmd.start_read)
        begin
            bit_next   = '0;
            tick_next  = '0;
            shift_next = '0;
            clock_next = 1'b1;
            new_next   = 1'b0;
            ready_next = 1'b1;
        end
        if (cmd.refuse)
        begin
            new_next   = 1'b0;
            ready_next = 1'b0;
            nr_next    = nr_reg + 1'b1;
        end
        if (cmd.clock_low)
            clock_next = 1'b0;
        if (cmd.shift_bit)
        begin
            shift_next = {shift_reg[DATA_BITS-2:0], data_pin};
            clock_next = 1'b1;
            bit_next   = stat.last_bit ? '0 : bit_reg + 1'b1;
        end
        if (cmd.gain_step)
        begin
            bit_next = stat.last_pulse ? '0 : bit_reg + 1'b1;
            if (!stat.last_pulse)
                clock_next = 1'b1;
        end
        if (cmd.finish)
        begin
            raw_next    = raw_code;
            weight_next = weight;
            new_next    = 1'b1;
            upd_next    = upd_reg + 1'b1;
        end
        if (cmd.load_out)
        begin
            out_valid_next                = 1'b1;
            out_word_next.clock_pin       = clock_reg;
            out_word_next.busy_res        = cmd.busy;
            out_word_next.ready_seen      = ready_reg;
            out_word_next.new_data        = new_reg;
            out_word_next.raw_code        = raw_reg;
            out_word_next.weight_q8       = weight_reg;
            out_word_next.update_total    = upd_reg;
            out_word_next.not_ready_total = nr_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg    <= '0;
            scale_reg     <= SCALE_RESET;
            gain_reg      <= GAIN_RESET;
            tick_reg      <= '0;
            bit_reg       <= '0;
            shift_reg     <= '0;
            clock_reg     <= 1'b0;
            ready_reg     <= 1'b0;
            new_reg       <= 1'b0;
            raw_reg       <= '0;
            weight_reg    <= '0;
            upd_reg       <= '0;
            nr_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            offset_reg    <= offset_next;
            scale_reg     <= scale_next;
            gain_reg      <= gain_next;
            tick_reg      <= tick_next;
            bit_reg       <= bit_next;
            shift_reg     <= shift_next;
            clock_reg     <= clock_next;
            ready_reg     <= ready_next;
            new_reg       <= new_next;
            raw_reg       <= raw_next;
            weight_reg    <= weight_next;
            upd_reg       <= upd_next;
            nr_reg        <= nr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    `ASSERT_ALWAYS(a_dp_emit_free, clk, rst_n, !(cmd.load_out && out_valid_reg), "result loaded over a waiting word")

endmodule

// ===== rtl/lcsr_ctrl.sv =====
`include "assert_macros.svh"

module lcsr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  lcsr_pkg::in_word_t  in_word,
    output logic                in_ready,
    input  lcsr_pkg::dp_stat_t  stat,
    output lcsr_pkg::dp_cmd_t   cmd
);
    import lcsr_pkg::*;

    phase_t phase_reg, phase_next;
    step_t  step_reg, step_next;
    logic   accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            step_reg  <= STEP_WAIT;
        end
        else
        begin
            phase_reg <= phase_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.busy   = (phase_reg != PH_IDLE);
        in_ready   = (step_reg == STEP_WAIT) && stat.out_free;
        accept     = in_valid && in_ready;

        case (step_reg)
            STEP_WAIT:
            begin
                if (accept)
                begin
                    step_next = STEP_EMIT;
                    case (phase_reg)
                        PH_IDLE:
                        begin
                            if (in_word.action)
                            begin
                                if (in_word.data_pin)
                                    cmd.refuse = 1'b1;
                                else
                                begin
                                    cmd.start_read = 1'b1;
                                    phase_next     = PH_BIT_HIGH;
                                end
                            end
                        end
                        PH_BIT_HIGH:
                        begin
                            cmd.tick_step = 1'b1;
                            if (stat.half_done)
                            begin
                                cmd.clock_low = 1'b1;
                                phase_next    = PH_BIT_LOW;
                            end
                        end
                        PH_BIT_LOW:
                        begin
                            cmd.tick_step = 1'b1;
                            if (stat.half_done)
                            begin
                                cmd.shift_bit = 1'b1;
                                phase_next    = stat.last_bit ? PH_GAIN_HIGH : PH_BIT_HIGH;
                            end
                        end
                        PH_GAIN_HIGH:
                        begin
                            cmd.tick_step = 1'b1;
                            if (stat.half_done)
                            begin
                                cmd.clock_low = 1'b1;
                                phase_next    = PH_GAIN_LOW;
                            end
                        end
                        PH_GAIN_LOW:
                        begin
                            cmd.tick_step = 1'b1;
                            if (stat.half_done)
                            begin
                                cmd.gain_step = 1'b1;
                                if (stat.last_pulse)
                                begin
                                    phase_next    = PH_IDLE;
                                    cmd.div_start = 1'b1;
                                    step_next     = STEP_DIV;
                                end
                                else
                                    phase_next = PH_GAIN_HIGH;
                            end
                        end
                        default:
                        begin
                            phase_next    = PH_IDLE;
                            cmd.clock_low = 1'b1;
                        end
                    endcase
                end
            end
            STEP_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.finish = 1'b1;
                    step_next  = STEP_EMIT;
                end
            end
            STEP_EMIT:
            begin
                cmd.load_out = 1'b1;
                step_next    = STEP_WAIT;
            end
            default: step_next = STEP_WAIT;
        endcase
    end

    `ASSERT_ALWAYS(a_ctrl_div_idle, clk, rst_n, step_reg != STEP_DIV || phase_reg == PH_IDLE, "division running during a serial read")

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

// Testbench for the load cell serial reader core.
//
// Every input word is one microsecond tick and every tick gives back exactly
// one output word, so the checker simply keeps a queue of predicted output
// words. Predictions are made at the rising edge where a tick is taken, and
// each output word that is taken is compared, field by field, with the oldest
// prediction in the queue.
//
// The stimulus is mostly well-formed reads: an update request with the data
// line low, followed by the ticks of the 24 data bits (with the wanted code
// bit placed on the tick where the converter line is sampled) and of the gain
// pulses. Requests while the reader is busy are mixed in, and they must be
// ignored. Refused requests, noise ticks and register changes fill the rest.
// Registers are only written once the input side has gone quiet and every
// predicted word has come back, which also gives the pause of the sender.
module tb_top;
    import lcsr_pkg::*;

    localparam int RANDOM_TICKS = 520;
    localparam int QUIET_FROM   = 500;
    localparam int QUIET_TO     = 700;
    localparam int END_CYCLES   = 100;
    localparam int REPORT_LIMIT = 10;

    localparam logic signed [OFFSET_W-1:0] OFFSET_LO = {1'b1, {(OFFSET_W-1){1'b0}}};
    localparam logic signed [OFFSET_W-1:0] OFFSET_HI = {1'b0, {(OFFSET_W-1){1'b1}}};

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    lcsr_in_if  in_ch();
    lcsr_out_if out_ch();

    load_cell_serial_reader_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    always #5 clk = ~clk;

    // Ticks waiting to be offered, and output words still to come back.
    in_word_t  tick_queue[$];
    out_word_t expected_words[$];

    int   ticks_queued  = 0;
    int   words_offered = 0;
    int   errors        = 0;
    logic in_fire;

    // Our own copy of the registers, at their reset values.
    logic signed [OFFSET_W-1:0] reg_offset = '0;
    logic [SCALE_W-1:0]         reg_scale  = SCALE_RESET;
    logic [GAIN_W-1:0]          reg_gain   = GAIN_RESET;

    // Our own copy of the reader state, at its reset values.
    phase_t              rd_phase    = PH_IDLE;
    int unsigned         rd_bits     = 0;
    int unsigned         rd_ticks    = 0;
    logic [31:0]         rd_shift    = '0;
    logic                rd_clock    = 1'b0;
    logic [CODE_W-1:0]   last_code   = '0;
    logic [WEIGHT_W-1:0] last_weight = '0;
    logic                seen_ready  = 1'b0;
    logic                fresh_data  = 1'b0;
    logic [COUNT_W-1:0]  reads_done  = '0;
    logic [COUNT_W-1:0]  refusals    = '0;

    function automatic void note_error(string msg);
        errors++;
        if (errors <= REPORT_LIMIT)
            $display("mismatch at %0t: %s", $realtime, msg);
    endfunction

    // Counts one tick of the current half period of the serial clock and
    // tells whether that half period has just run out.
    function automatic bit half_elapsed();
        rd_ticks++;
        if (rd_ticks >= HALF_PERIOD_TICKS)
        begin
            rd_ticks = 0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Weight in Q24.8 grams: the magnitude of (code - offset), shifted up by
    // 24 places, is divided by the Q16.16 scale, truncated, and saturated to
    // the signed 32-bit range with the sign put back afterwards.
    function automatic logic [WEIGHT_W-1:0] scaled_weight(logic [CODE_W-1:0] code);
        longint      diff;
        logic [63:0] mag;
        logic [63:0] quo;
        diff = longint'(code) - longint'(reg_offset);
        mag  = (diff < 0) ? -diff : diff;
        quo  = (mag << FRAC_SHIFT) / {32'd0, reg_scale};
        if (diff < 0)
        begin
            if (quo >= 64'h8000_0000)
                return WEIGHT_MIN;
            quo = -quo;
            return quo[WEIGHT_W-1:0];
        end
        if (quo > 64'h7FFF_FFFF)
            return WEIGHT_MAX;
        return quo[WEIGHT_W-1:0];
    endfunction

    // Advances the reader by one tick and returns the word it should give.
    function automatic out_word_t advance_reader(in_word_t w);
        out_word_t   r;
        int unsigned pulses;
        // A gain setting of zero still gives one pulse.
        pulses = (reg_gain == '0) ? 1 : reg_gain;
        case (rd_phase)
            PH_IDLE:
            begin
                if (w.action)
                begin
                    fresh_data = 1'b0;
                    seen_ready = !w.data_pin;
                    if (w.data_pin)
                        refusals++;
                    else
                    begin
                        rd_phase = PH_BIT_HIGH;
                        rd_bits  = 0;
                        rd_ticks = 0;
                        rd_shift = '0;
                        rd_clock = 1'b1;
                    end
                end
            end
            PH_BIT_HIGH:
            begin
                if (half_elapsed())
                begin
                    rd_clock = 1'b0;
                    rd_phase = PH_BIT_LOW;
                end
            end
            PH_BIT_LOW:
            begin
                // The data line is sampled on the last tick of the low time.
                if (half_elapsed())
                begin
                    rd_shift = {rd_shift[30:0], w.data_pin};
                    rd_bits++;
                    rd_clock = 1'b1;
                    if (rd_bits >= DATA_BITS)
                    begin
                        rd_bits  = 0;
                        rd_phase = PH_GAIN_HIGH;
                    end
                    else
                        rd_phase = PH_BIT_HIGH;
                end
            end
            PH_GAIN_HIGH:
            begin
                if (half_elapsed())
                begin
                    rd_clock = 1'b0;
                    rd_phase = PH_GAIN_LOW;
                end
            end
            PH_GAIN_LOW:
            begin
                if (half_elapsed())
                begin
                    rd_bits++;
                    if (rd_bits >= pulses)
                    begin
                        // End of the last gain pulse: the read completes here.
                        rd_bits     = 0;
                        rd_phase    = PH_IDLE;
                        last_code   = rd_shift[CODE_W-1:0] ^ CODE_FLIP;
                        last_weight = scaled_weight(last_code);
                        fresh_data  = 1'b1;
                        reads_done++;
                    end
                    else
                    begin
                        rd_clock = 1'b1;
                        rd_phase = PH_GAIN_HIGH;
                    end
                end
            end
            default:
            begin
                rd_phase = PH_IDLE;
                rd_clock = 1'b0;
            end
        endcase
        r.clock_pin       = rd_clock;
        r.busy_res        = (rd_phase != PH_IDLE);
        r.ready_seen      = seen_ready;
        r.new_data        = fresh_data;
        r.raw_code        = last_code;
        r.weight_q8       = last_weight;
        r.update_total    = reads_done;
        r.not_ready_total = refusals;
        return r;
    endfunction

    // Lists every field in which the word taken differs from the prediction.
    function automatic string field_diffs(out_word_t e, out_word_t g);
        string s;
        s = "";
        if (g.clock_pin !== e.clock_pin)
            s = {s, $sformatf(" clock_pin exp %b got %b", e.clock_pin, g.clock_pin)};
        if (g.busy_res !== e.busy_res)
            s = {s, $sformatf(" busy_res exp %b got %b", e.busy_res, g.busy_res)};
        if (g.ready_seen !== e.ready_seen)
            s = {s, $sformatf(" ready_seen exp %b got %b", e.ready_seen, g.ready_seen)};
        if (g.new_data !== e.new_data)
            s = {s, $sformatf(" new_data exp %b got %b", e.new_data, g.new_data)};
        if (g.raw_code !== e.raw_code)
            s = {s, $sformatf(" raw_code exp %h got %h", e.raw_code, g.raw_code)};
        if (g.weight_q8 !== e.weight_q8)
            s = {s, $sformatf(" weight_q8 exp %h got %h", e.weight_q8, g.weight_q8)};
        if (g.update_total !== e.update_total)
            s = {s, $sformatf(" update_total exp %0d got %0d", e.update_total,
                              g.update_total)};
        if (g.not_ready_total !== e.not_ready_total)
            s = {s, $sformatf(" not_ready_total exp %0d got %0d", e.not_ready_total,
                              g.not_ready_total)};
        return s;
    endfunction

    // Driver: offers the next tick and sets the output ready at the falling
    // edge. Both sides stall about a quarter of the time, except for a quiet
    // stretch of the run where neither side stalls at all.
    always @(negedge clk)
    begin : tick_driver
        int   stall_pct;
        logic offer;
        if (!rst_n)
        begin
            in_ch.valid  <= 1'b0;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            stall_pct = (words_offered >= QUIET_FROM && words_offered < QUIET_TO) ? 0 : 25;
            if (!in_ch.valid || in_fire)
            begin
                offer = (tick_queue.size() != 0) && ($urandom_range(99) >= stall_pct);
                if (offer)
                begin
                    in_ch.word <= tick_queue.pop_front();
                    words_offered++;
                end
                in_ch.valid <= offer;
            end
            out_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Monitor: checks the output word taken at this edge against the oldest
    // prediction, then predicts the word for the tick taken at this edge.
    // Checking comes first, so a word that arrives too early cannot be
    // matched against a tick taken in the same cycle.
    always @(posedge clk)
    begin : word_monitor
        out_word_t want;
        string     bad;
        if (!rst_n)
            in_fire <= 1'b0;
        else
        begin
            in_fire <= in_ch.valid && in_ch.ready;
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_words.size() == 0)
                    note_error($sformatf("word %h with none predicted", out_ch.word));
                else
                begin
                    want = expected_words.pop_front();
                    bad  = field_diffs(want, out_ch.word);
                    if (bad != "")
                        note_error(bad);
                end
            end
            if (in_ch.valid && in_ch.ready)
                expected_words.push_back(advance_reader(in_ch.word));
        end
    end

    task automatic queue_tick(logic action, logic data_pin);
        in_word_t w;
        w.action   = action;
        w.data_pin = data_pin;
        tick_queue.push_back(w);
        ticks_queued++;
    endtask

    // Update requests sprinkled into a running read; the reader must ignore
    // every one of them.
    function automatic logic busy_poke();
        return ($urandom_range(99) < 10);
    endfunction

    // Waits until the input side has nothing left to offer and every
    // predicted word has come back. Sampled just after the rising edge so
    // that the driver and the monitor have both settled.
    task automatic settle();
        do
        begin
            @(posedge clk);
            #1;
        end
        while (tick_queue.size() != 0 || (in_ch.valid && !in_fire)
               || expected_words.size() != 0);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            CFG_ZERO_OFFSET: reg_offset = value[OFFSET_W-1:0];
            CFG_SCALE:       if (value != '0) reg_scale = value;
            CFG_GAIN:        reg_gain = value[GAIN_W-1:0];
            default:         ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Rewrites all three registers once everything is quiet. Offsets and
    // scales lean towards their extremes; a zero scale is sometimes written
    // to show that it is ignored.
    task automatic random_config();
        logic signed [OFFSET_W-1:0] off;
        logic [SCALE_W-1:0]         scl;
        settle();
        case ($urandom_range(4))
            0:       off = OFFSET_LO;
            1:       off = OFFSET_HI;
            2:       off = '0;
            default: off = OFFSET_W'($urandom());
        endcase
        case ($urandom_range(6))
            0:       scl = 32'd1;
            1:       scl = '1;
            2:       scl = '0;
            3:       scl = SCALE_RESET;
            4:       scl = $urandom_range(32'h0100_0000, 1);
            default: scl = $urandom();
        endcase
        write_reg(CFG_ZERO_OFFSET, CFG_DATA_W'(off));
        write_reg(CFG_SCALE, scl);
        write_reg(CFG_GAIN, CFG_DATA_W'($urandom_range(3)));
    endtask

    // One well-formed read: a request with the data line low, then the ticks
    // of each data bit with the wanted code bit on the sampling tick, then
    // the ticks of the gain pulses. With pause_bit in range the sender stops
    // before that bit and the registers are rewritten in the middle of the read.
    task automatic run_read(logic [DATA_BITS-1:0] code, int pause_bit);
        int pulses;
        queue_tick(1'b1, 1'b0);
        for (int b = 0; b < DATA_BITS; b++)
        begin
            if (b == pause_bit)
                random_config();
            for (int t = 1; t <= 2 * HALF_PERIOD_TICKS; t++)
                queue_tick(busy_poke(), (t == 2 * HALF_PERIOD_TICKS) ?
                           code[DATA_BITS-1-b] : 1'($urandom_range(1)));
        end
        pulses = (reg_gain == '0) ? 1 : int'(reg_gain);
        repeat (2 * HALF_PERIOD_TICKS * pulses)
            queue_tick(busy_poke(), 1'($urandom_range(1)));
        repeat ($urandom_range(2))
            queue_tick(1'b0, 1'($urandom_range(1)));
    endtask

    initial
    begin : stimulus
        int                   random_end;
        int                   pick;
        logic [DATA_BITS-1:0] code;
        in_ch.valid  = 1'b0;
        in_ch.word   = '0;
        out_ch.ready = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_ZERO_OFFSET;
        cfg_data     = '0;
        rst_n        = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. Plain ticks on both line levels, a refused request,
        // then a read of an all-ones code with the registers at reset.
        queue_tick(1'b0, 1'b0);
        queue_tick(1'b0, 1'b1);
        queue_tick(1'b1, 1'b1);
        run_read('1, -1);

        // Most negative offset with the smallest scale and three gain pulses:
        // the weight saturates at the top of the range.
        settle();
        write_reg(CFG_ZERO_OFFSET, CFG_DATA_W'(OFFSET_LO));
        write_reg(CFG_SCALE, 32'd1);
        write_reg(CFG_GAIN, CFG_DATA_W'(3));
        run_read('1, -1);
        queue_tick(1'b1, 1'b1);

        // Most positive offset with an all-zeros code saturates at the bottom.
        // The zero scale write must leave the scale at one, and a gain of
        // zero must still give one pulse.
        settle();
        write_reg(CFG_ZERO_OFFSET, CFG_DATA_W'(OFFSET_HI));
        write_reg(CFG_SCALE, '0);
        write_reg(CFG_GAIN, '0);
        run_read('0, -1);

        // Largest scale, two pulses, and registers rewritten halfway through.
        settle();
        write_reg(CFG_ZERO_OFFSET, '0);
        write_reg(CFG_SCALE, '1);
        write_reg(CFG_GAIN, CFG_DATA_W'(2));
        run_read(DATA_BITS'($urandom()), DATA_BITS / 2);

        // Back to reset values for an ordinary read.
        settle();
        write_reg(CFG_ZERO_OFFSET, '0);
        write_reg(CFG_SCALE, SCALE_RESET);
        write_reg(CFG_GAIN, CFG_DATA_W'(GAIN_RESET));
        run_read(DATA_BITS'(24'h12_3456), -1);

        // Random part: mostly complete reads with random codes, with refused
        // requests, noise ticks and register changes in between.
        random_end = ticks_queued + RANDOM_TICKS;
        while (ticks_queued < random_end)
        begin
            pick = $urandom_range(99);
            if (pick < 12)
                random_config();
            else if (pick < 60)
            begin
                case ($urandom_range(5))
                    0:       code = '0;
                    1:       code = '1;
                    default: code = DATA_BITS'($urandom());
                endcase
                run_read(code, ($urandom_range(7) == 0) ?
                         int'($urandom_range(DATA_BITS - 1)) : -1);
            end
            else if (pick < 72)
                queue_tick(1'b1, 1'b1);
            else
                repeat ($urandom_range(6, 1))
                    queue_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
        end

        // Let everything drain, then give the reader time to show any stray
        // word before the verdict.
        settle();
        repeat (END_CYCLES) @(posedge clk);
        if (expected_words.size() != 0)
            note_error($sformatf("%0d predicted words never came",
                                 expected_words.size()));
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Guard against a hang: far beyond the slowest correct run.
    initial
    begin : watchdog
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/lcsr_pkg.sv
rtl/lcsr_in_if.sv
rtl/lcsr_out_if.sv
rtl/lcsr_div.sv
rtl/lcsr_dp.sv
rtl/lcsr_ctrl.sv
rtl/load_cell_serial_reader_core.sv
verif/tb_top.sv
